/* src/tcce_pkg.sv */
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared types and constants of the text console cursor engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

	// Field widths
	localparam int unsigned MODE_W     = 2;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned ROW_W      = 8;
	localparam int unsigned COL_W      = 9;
	localparam int unsigned GLYPH_W    = 7;
	localparam int unsigned PX_W       = 12;

	// Stream packing
	localparam int unsigned S_TDATA_W  = 32;
	localparam int unsigned S_TUSER_W  = MODE_W;
	localparam int unsigned M_TDATA_W  = 48;
	localparam int unsigned M_TDATA_PAD = M_TDATA_W - (GLYPH_W + 2 * COL_W + 2 * ROW_W);
	localparam int unsigned M_TUSER_W  = 3;

	// Configuration port
	localparam int unsigned CFG_INDEX_W = 8;
	localparam logic [CFG_INDEX_W-1:0] REG_WIDTH  = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT = CFG_INDEX_W'(1);
	localparam int unsigned WIDTH_PX_RST  = 640;
	localparam int unsigned HEIGHT_PX_RST = 480;

	// Glyph cell defaults
	localparam int unsigned GLYPH_WIDTH_DEF  = 8;
	localparam int unsigned GLYPH_HEIGHT_DEF = 16;

	// Text grid limits (one bit wider than the cursor fields)
	localparam int unsigned COLS_W   = COL_W + 1;
	localparam int unsigned ROWS_W   = ROW_W + 1;
	localparam int unsigned COLS_MAX = 512;
	localparam int unsigned ROWS_MAX = 256;

	// Characters
	localparam logic [BYTE_W-1:0]  CHAR_LF    = 8'h0A;
	localparam logic [BYTE_W-1:0]  CHAR_CR    = 8'h0D;
	localparam logic [BYTE_W-1:0]  CHAR_TAB   = 8'h09;
	localparam logic [BYTE_W-1:0]  ASCII_MAX  = 8'h7F;
	localparam logic [GLYPH_W-1:0] GLYPH_REPL = 7'h3F;
	localparam int unsigned        TAB_STEP   = 8;

	typedef enum logic [MODE_W-1:0] {
		MODE_WRITE = 2'd0,
		MODE_SET   = 2'd1,
		MODE_CLEAR = 2'd2,
		MODE_NOP   = 2'd3
	} mode_t;

	// UTF-8 decoder states: what the next continuation byte must look like
	typedef enum logic [7:0] {
		DEC_ACCEPT = 8'b0000_0001,
		DEC_NEED1  = 8'b0000_0010,
		DEC_NEED2  = 8'b0000_0100,
		DEC_NEED3  = 8'b0000_1000,
		DEC_E0     = 8'b0001_0000,
		DEC_ED     = 8'b0010_0000,
		DEC_F0     = 8'b0100_0000,
		DEC_F4     = 8'b1000_0000
	} dec_state_t;

endpackage

/* src/text_console_cursor_engine_unit.sv */
// ----------------------------------------------------------------------------
// text_console_cursor_engine_unit
// Console front end: cursor tracking, tab/newline handling, UTF-8 decode.
//
// Requests enter on the s_ stream (tuser = mode, tdata = byte, row, column)
// and each gives exactly one result on the m_ stream (tuser = draw, scroll,
// clear flags; tdata = glyph, draw position, cursor after the request).
// The screen size in pixels is written on the cfg channel, index 0 width and
// index 1 height; cfg_ready is always high and the write takes effect on the
// next cycle. The text grid size is worked out at the write itself.
// A request passes through an input register, then the cursor and decoder
// logic into the result register. One request per cycle is sustained while
// m_tready is high; the cursor and decoder state close their loop in that
// single logic stage.
// When m_tready is low the result register holds and the input register
// still takes one more request; after that s_tready drops until the result
// is taken.
// Reset clears the cursor to the home position, returns the decoder to its
// accept state and loads the 640 by 480 screen size.
// ----------------------------------------------------------------------------
module text_console_cursor_engine_unit #(
	parameter int unsigned GLYPH_WIDTH  = tcce_pkg::GLYPH_WIDTH_DEF,
	parameter int unsigned GLYPH_HEIGHT = tcce_pkg::GLYPH_HEIGHT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// byte_value [7:0], new_row [15:8], new_col [24:16]
	input  logic [tcce_pkg::S_TDATA_W-1:0]    s_tdata,
	// mode [1:0]
	input  logic [tcce_pkg::S_TUSER_W-1:0]    s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// glyph_code [6:0], draw_col [15:7], draw_row [23:16],
	// cursor column [32:24], cursor row [40:33]
	output logic [tcce_pkg::M_TDATA_W-1:0]    m_tdata,
	// draw [0], scroll [1], clear [2]
	output logic [tcce_pkg::M_TUSER_W-1:0]    m_tuser,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tcce_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [tcce_pkg::PX_W-1:0]         cfg_data
);
	import tcce_pkg::*;

	// Division by the glyph size as a multiply by a rounded-up reciprocal;
	// exact for 12-bit pixel counts and divisors up to 32.
	localparam int unsigned RECIP_SHIFT = 24;
	localparam int unsigned PROD_W      = 36;
	localparam int unsigned COL_RECIP   =
		((1 << RECIP_SHIFT) + GLYPH_WIDTH - 1) / GLYPH_WIDTH;
	localparam int unsigned ROW_RECIP   =
		((1 << RECIP_SHIFT) + GLYPH_HEIGHT - 1) / GLYPH_HEIGHT;

	localparam int unsigned COLS_DIV = WIDTH_PX_RST / GLYPH_WIDTH;
	localparam int unsigned ROWS_DIV = HEIGHT_PX_RST / GLYPH_HEIGHT;
	localparam int unsigned COLS_RST =
		(COLS_DIV < 1) ? 1 : ((COLS_DIV > COLS_MAX) ? COLS_MAX : COLS_DIV);
	localparam int unsigned ROWS_RST =
		(ROWS_DIV < 1) ? 1 : ((ROWS_DIV > ROWS_MAX) ? ROWS_MAX : ROWS_DIV);

	function automatic logic [COLS_W-1:0] clamp_cols(input logic [PX_W-1:0] q);
		logic [COLS_W-1:0] r;
		if (q == '0) begin
			r = COLS_W'(1);
		end else if (q > PX_W'(COLS_MAX)) begin
			r = COLS_W'(COLS_MAX);
		end else begin
			r = COLS_W'(q);
		end
		return r;
	endfunction

	function automatic logic [ROWS_W-1:0] clamp_rows(input logic [PX_W-1:0] q);
		logic [ROWS_W-1:0] r;
		if (q == '0) begin
			r = ROWS_W'(1);
		end else if (q > PX_W'(ROWS_MAX)) begin
			r = ROWS_W'(ROWS_MAX);
		end else begin
			r = ROWS_W'(q);
		end
		return r;
	endfunction

	// Configuration
	logic [PROD_W-1:0] col_prod;
	logic [PROD_W-1:0] row_prod;
	logic [COLS_W-1:0] cols_q;
	logic [ROWS_W-1:0] rows_q;

	assign cfg_ready = 1'b1;
	assign col_prod  = PROD_W'(cfg_data) * PROD_W'(COL_RECIP);
	assign row_prod  = PROD_W'(cfg_data) * PROD_W'(ROW_RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= COLS_W'(COLS_RST);
			rows_q <= ROWS_W'(ROWS_RST);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_WIDTH:  cols_q <= clamp_cols(col_prod[RECIP_SHIFT +: PX_W]);
				REG_HEIGHT: rows_q <= clamp_rows(row_prod[RECIP_SHIFT +: PX_W]);
				default: ;
			endcase
		end
	end

	// Input register
	logic              valid_s1;
	mode_t             mode_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic [ROW_W-1:0]  nrow_s1;
	logic [COL_W-1:0]  ncol_s1;
	logic              advance;
	logic              out_valid_q;

	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			mode_s1 <= mode_t'(s_tuser);
			byte_s1 <= s_tdata[BYTE_W-1:0];
			nrow_s1 <= s_tdata[BYTE_W +: ROW_W];
			ncol_s1 <= s_tdata[BYTE_W + ROW_W +: COL_W];
		end
	end

	// Cursor and decoder state. Only whether a finished code point is ASCII
	// matters, and a multi-byte sequence never yields one, so no code point
	// bits are kept.
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	dec_state_t       dec_q;

	logic [COLS_W-1:0]  col_n;
	logic [ROWS_W-1:0]  row_n;
	logic [COLS_W-1:0]  tab_col;
	dec_state_t         dec_n;
	dec_state_t         cont_next;
	logic [BYTE_W-1:0]  cont_lo;
	logic [BYTE_W-1:0]  cont_hi;
	logic               emit;
	logic [GLYPH_W-1:0] glyph_n;
	logic               draw_n;
	logic [COL_W-1:0]   dcol_n;
	logic [ROW_W-1:0]   drow_n;
	logic               scroll_n;
	logic               clear_n;

	assign tab_col = (COLS_W'(col_q) + COLS_W'(TAB_STEP)) & ~COLS_W'(TAB_STEP - 1);

	// Continuation byte window and follow-on state
	always_comb begin
		cont_lo   = 8'h80;
		cont_hi   = 8'hBF;
		cont_next = DEC_ACCEPT;
		case (dec_q)
			DEC_NEED1: cont_next = DEC_ACCEPT;
			DEC_NEED2: cont_next = DEC_NEED1;
			DEC_NEED3: cont_next = DEC_NEED2;
			DEC_E0: begin
				cont_lo   = 8'hA0;
				cont_next = DEC_NEED1;
			end
			DEC_ED: begin
				cont_hi   = 8'h9F;
				cont_next = DEC_NEED1;
			end
			DEC_F0: begin
				cont_lo   = 8'h90;
				cont_next = DEC_NEED2;
			end
			DEC_F4: begin
				cont_hi   = 8'h8F;
				cont_next = DEC_NEED2;
			end
			default: ;
		endcase
	end

	always_comb begin
		col_n    = COLS_W'(col_q);
		row_n    = ROWS_W'(row_q);
		dec_n    = dec_q;
		emit     = 1'b0;
		glyph_n  = GLYPH_REPL;
		draw_n   = 1'b0;
		dcol_n   = '0;
		drow_n   = '0;
		scroll_n = 1'b0;
		clear_n  = 1'b0;
		case (mode_s1)
			MODE_WRITE: begin
				if (byte_s1 == CHAR_LF) begin
					col_n = '0;
					row_n = row_n + ROWS_W'(1);
					dec_n = DEC_ACCEPT;
				end else if (byte_s1 == CHAR_CR) begin
					col_n = '0;
					dec_n = DEC_ACCEPT;
				end else if (byte_s1 == CHAR_TAB) begin
					col_n = tab_col;
					if (col_n >= cols_q) begin
						col_n = '0;
						row_n = row_n + ROWS_W'(1);
					end
					dec_n = DEC_ACCEPT;
				end else if (dec_q == DEC_ACCEPT) begin
					// lead byte
					if (byte_s1 <= ASCII_MAX) begin
						emit    = 1'b1;
						glyph_n = byte_s1[GLYPH_W-1:0];
					end else if (byte_s1 inside {[8'hC2:8'hDF]}) begin
						dec_n = DEC_NEED1;
					end else if (byte_s1 inside {[8'hE0:8'hEF]}) begin
						dec_n = (byte_s1 == 8'hE0) ? DEC_E0 :
							(byte_s1 == 8'hED) ? DEC_ED : DEC_NEED2;
					end else if (byte_s1 inside {[8'hF0:8'hF4]}) begin
						dec_n = (byte_s1 == 8'hF0) ? DEC_F0 :
							(byte_s1 == 8'hF4) ? DEC_F4 : DEC_NEED3;
					end else begin
						emit = 1'b1;
					end
				end else begin
					// continuation byte; reject or finish draws the replacement
					if (byte_s1 < cont_lo || byte_s1 > cont_hi) begin
						dec_n = DEC_ACCEPT;
						emit  = 1'b1;
					end else begin
						dec_n = cont_next;
						emit  = (cont_next == DEC_ACCEPT);
					end
				end
				if (emit) begin
					draw_n = 1'b1;
					dcol_n = col_q;
					drow_n = row_q;
					col_n  = col_n + COLS_W'(1);
					if (col_n >= cols_q) begin
						col_n = '0;
						row_n = row_n + ROWS_W'(1);
					end
				end
				if (row_n >= rows_q) begin
					scroll_n = 1'b1;
					row_n    = rows_q - ROWS_W'(1);
				end
			end
			MODE_SET: begin
				if (ROWS_W'(nrow_s1) < rows_q) begin
					row_n = ROWS_W'(nrow_s1);
				end
				if (COLS_W'(ncol_s1) < cols_q) begin
					col_n = COLS_W'(ncol_s1);
				end
			end
			MODE_CLEAR: begin
				clear_n = 1'b1;
				col_n   = '0;
				row_n   = '0;
			end
			default: ;
		endcase
	end

	// Result register and state update
	logic [GLYPH_W-1:0] glyph_q;
	logic [COL_W-1:0]   dcol_q;
	logic [ROW_W-1:0]   drow_q;
	logic               draw_q;
	logic               scroll_q;
	logic               clear_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			col_q       <= '0;
			row_q       <= '0;
			dec_q       <= DEC_ACCEPT;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				col_q <= col_n[COL_W-1:0];
				row_q <= row_n[ROW_W-1:0];
				dec_q <= dec_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			glyph_q  <= draw_n ? glyph_n : '0;
			dcol_q   <= dcol_n;
			drow_q   <= drow_n;
			draw_q   <= draw_n;
			scroll_q <= scroll_n;
			clear_q  <= clear_n;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {M_TDATA_PAD'(0), row_q, col_q, drow_q, dcol_q, glyph_q};
	assign m_tuser  = {clear_q, scroll_q, draw_q};

endmodule

/* src/tcce_checker.sv */
// ----------------------------------------------------------------------------
// tcce_checker
// Port-level checks on the result stream of the cursor engine.
// ----------------------------------------------------------------------------
module tcce_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [tcce_pkg::M_TDATA_W-1:0]    m_tdata,
	input logic [tcce_pkg::M_TUSER_W-1:0]    m_tuser
);
	import tcce_pkg::*;

	// Hold a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// Clear homes the cursor and draws nothing
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2] |->
			!m_tuser[0] && !m_tuser[1] && m_tdata[40:24] == '0)
		else $error("clear result not at home");

	// No glyph means zeroed glyph fields
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[23:0] == '0)
		else $error("glyph fields set without draw");

	// A draw ends one column further on or at the start of a line
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |->
			m_tdata[32:24] == m_tdata[15:7] + 9'd1 || m_tdata[32:24] == '0)
		else $error("cursor did not advance after draw");

endmodule

bind text_console_cursor_engine_unit tcce_checker u_tcce_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

/* tb/cursor_engine_checker.sv */
// ----------------------------------------------------------------------------
// cursor_engine_checker
// Watches the request, result and register channels of the console cursor
// engine. Each accepted request is run through a cycle-free model of the
// cursor and UTF-8 decoder. The result it gives is queued, and every result
// taken from the block is compared field by field with the oldest entry.
// ----------------------------------------------------------------------------
module cursor_engine_checker #(
	parameter int unsigned GLYPH_WIDTH  = tcce_pkg::GLYPH_WIDTH_DEF,
	parameter int unsigned GLYPH_HEIGHT = tcce_pkg::GLYPH_HEIGHT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	input  logic                              s_tready,
	input  logic [tcce_pkg::S_TDATA_W-1:0]    s_tdata,
	input  logic [tcce_pkg::S_TUSER_W-1:0]    s_tuser,
	input  logic                              m_tvalid,
	input  logic                              m_tready,
	input  logic [tcce_pkg::M_TDATA_W-1:0]    m_tdata,
	input  logic [tcce_pkg::M_TUSER_W-1:0]    m_tuser,
	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic [tcce_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [tcce_pkg::PX_W-1:0]         cfg_data,
	output int unsigned                       err_count,
	output int unsigned                       outstanding
);
	import tcce_pkg::*;

	typedef struct packed {
		logic               draw;
		logic [GLYPH_W-1:0] glyph;
		logic [COL_W-1:0]   draw_col;
		logic [ROW_W-1:0]   draw_row;
		logic               scroll;
		logic               clear;
		logic [COL_W-1:0]   end_col;
		logic [ROW_W-1:0]   end_row;
	} console_result_t;

	typedef enum logic [1:0] {
		FEED_MORE,
		FEED_DONE,
		FEED_BAD
	} feed_t;

	logic [PX_W-1:0]  scr_width;
	logic [PX_W-1:0]  scr_height;
	logic [COL_W-1:0] cur_col;
	logic [ROW_W-1:0] cur_row;
	dec_state_t       dec_st;
	logic [20:0]      codepoint;

	console_result_t  console_result_q[$];
	int unsigned      results_seen;

	task automatic report_mismatch(input string what, input int unsigned want,
			input int unsigned got);
		$display("result %0d: %s expected %0d got %0d", results_seen, what, want, got);
		err_count++;
	endtask

	task automatic check_field(input string what, input int unsigned want,
			input int unsigned got);
		if (want != got)
			report_mismatch(what, want, got);
	endtask

	task automatic predict_console_result(input mode_t op, input logic [BYTE_W-1:0] ch,
			input logic [ROW_W-1:0] req_row, input logic [COL_W-1:0] req_col,
			output console_result_t res);
		int unsigned cols, rows, col, row;
		feed_t fed;
		logic [7:0] lo, hi;
		res = '0;
		fed = FEED_MORE;
		cols = scr_width / GLYPH_WIDTH;
		if (cols < 1) cols = 1;
		if (cols > COLS_MAX) cols = COLS_MAX;
		rows = scr_height / GLYPH_HEIGHT;
		if (rows < 1) rows = 1;
		if (rows > ROWS_MAX) rows = ROWS_MAX;
		col = cur_col;
		row = cur_row;
		case (op)
		MODE_WRITE: begin
			if (ch == CHAR_LF || ch == CHAR_CR || ch == CHAR_TAB) begin
				dec_st = DEC_ACCEPT;
				codepoint = '0;
				if (ch == CHAR_TAB) begin
					col = (col + TAB_STEP) & ~(TAB_STEP - 1);
					if (col >= cols) begin
						col = 0;
						row++;
					end
				end else begin
					col = 0;
					if (ch == CHAR_LF) row++;
				end
			end else begin
				if (dec_st == DEC_ACCEPT) begin
					if (ch <= ASCII_MAX) begin
						codepoint = 21'(ch);
						fed = FEED_DONE;
					end else if (ch >= 8'hC2 && ch <= 8'hDF) begin
						codepoint = 21'(ch[4:0]);
						dec_st = DEC_NEED1;
					end else if (ch >= 8'hE0 && ch <= 8'hEF) begin
						codepoint = 21'(ch[3:0]);
						dec_st = (ch == 8'hE0) ? DEC_E0 : (ch == 8'hED) ? DEC_ED : DEC_NEED2;
					end else if (ch >= 8'hF0 && ch <= 8'hF4) begin
						codepoint = 21'(ch[2:0]);
						dec_st = (ch == 8'hF0) ? DEC_F0 : (ch == 8'hF4) ? DEC_F4 : DEC_NEED3;
					end else begin
						codepoint = '0;
						fed = FEED_BAD;
					end
				end else begin
					lo = 8'h80;
					hi = 8'hBF;
					case (dec_st)
					DEC_E0: lo = 8'hA0;
					DEC_ED: hi = 8'h9F;
					DEC_F0: lo = 8'h90;
					DEC_F4: hi = 8'h8F;
					default: ;
					endcase
					if (ch < lo || ch > hi) begin
						dec_st = DEC_ACCEPT;
						codepoint = '0;
						fed = FEED_BAD;
					end else begin
						codepoint = {codepoint[14:0], ch[5:0]};
						case (dec_st)
						DEC_NEED1: begin
							dec_st = DEC_ACCEPT;
							fed = FEED_DONE;
						end
						DEC_NEED2, DEC_E0, DEC_ED: dec_st = DEC_NEED1;
						default: dec_st = DEC_NEED2;
						endcase
					end
				end
				if (fed != FEED_MORE) begin
					res.draw = 1'b1;
					res.glyph = (fed == FEED_DONE && codepoint <= ASCII_MAX) ?
						codepoint[GLYPH_W-1:0] : GLYPH_REPL;
					res.draw_col = col[COL_W-1:0];
					res.draw_row = row[ROW_W-1:0];
					col++;
					if (col >= cols) begin
						col = 0;
						row++;
					end
				end
			end
			// pin to the last line, also for a cursor left below the screen
			if (row >= rows) begin
				res.scroll = 1'b1;
				row = rows - 1;
			end
		end
		MODE_SET: begin
			if (req_row < rows) row = req_row;
			if (req_col < cols) col = req_col;
		end
		MODE_CLEAR: begin
			res.clear = 1'b1;
			col = 0;
			row = 0;
		end
		default: ;
		endcase
		cur_col = col[COL_W-1:0];
		cur_row = row[ROW_W-1:0];
		res.end_col = cur_col;
		res.end_row = cur_row;
	endtask

	always @(posedge clk or negedge arst_n) begin
		console_result_t got, want;
		if (!arst_n) begin
			scr_width = PX_W'(WIDTH_PX_RST);
			scr_height = PX_W'(HEIGHT_PX_RST);
			cur_col = '0;
			cur_row = '0;
			dec_st = DEC_ACCEPT;
			codepoint = '0;
			console_result_q.delete();
			err_count = 0;
			results_seen = 0;
			outstanding <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.draw     = m_tuser[0];
				got.scroll   = m_tuser[1];
				got.clear    = m_tuser[2];
				got.glyph    = m_tdata[6:0];
				got.draw_col = m_tdata[15:7];
				got.draw_row = m_tdata[23:16];
				got.end_col  = m_tdata[32:24];
				got.end_row  = m_tdata[40:33];
				if (console_result_q.size() == 0) begin
					report_mismatch("result with none pending", 0, 1);
				end else begin
					want = console_result_q.pop_front();
					check_field("draw", want.draw, got.draw);
					check_field("glyph_code", want.glyph, got.glyph);
					check_field("draw_col", want.draw_col, got.draw_col);
					check_field("draw_row", want.draw_row, got.draw_row);
					check_field("scroll", want.scroll, got.scroll);
					check_field("clear", want.clear, got.clear);
					check_field("cursor column", want.end_col, got.end_col);
					check_field("cursor row", want.end_row, got.end_row);
				end
				results_seen++;
			end
			if (s_tvalid && s_tready) begin
				predict_console_result(mode_t'(s_tuser), s_tdata[7:0], s_tdata[15:8],
					s_tdata[24:16], want);
				console_result_q.push_back(want);
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				REG_WIDTH:  scr_width = cfg_data;
				REG_HEIGHT: scr_height = cfg_data;
				default: ;
				endcase
			end
			// registered, so a reader at the clock edge sees a settled count
			outstanding <= console_result_q.size();
		end
	end

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the console cursor engine. A directed opening hits
// the control bytes, decoder edge cases and every mode; then four phases
// with different screen sizes send random byte streams made mostly of
// well-formed UTF-8, with broken sequences and noise mixed in, under random
// backpressure on both sides in the first two phases.
// ----------------------------------------------------------------------------
module tb_top;
	import tcce_pkg::*;

	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LO = CFG_INDEX_W'(2);
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_HI = CFG_INDEX_W'(255);

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [S_TDATA_W-1:0]   s_tdata   = '0;
	logic [S_TUSER_W-1:0]   s_tuser   = '0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [M_TDATA_W-1:0]   m_tdata;
	logic [M_TUSER_W-1:0]   m_tuser;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [PX_W-1:0]        cfg_data  = '0;

	int unsigned err_count;
	int unsigned outstanding;

	int unsigned tx_idle_pct = 0;
	int unsigned rx_idle_pct = 0;
	logic        rx_hold_req = 1'b0;
	int unsigned hold_left   = 0;
	int unsigned items_sent  = 0;
	int unsigned cols_now    = WIDTH_PX_RST / GLYPH_WIDTH_DEF;
	int unsigned rows_now    = HEIGHT_PX_RST / GLYPH_HEIGHT_DEF;

	text_console_cursor_engine_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	cursor_engine_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.err_count   (err_count),
		.outstanding (outstanding)
	);

	always #5 clk = ~clk;

	// result side: random stalls, or a long hold-off when asked
	always @(posedge clk) begin
		if (rx_hold_req) begin
			hold_left = 400;
			rx_hold_req = 1'b0;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	task automatic send_req(input mode_t op, input logic [BYTE_W-1:0] ch,
			input logic [ROW_W-1:0] row_req, input logic [COL_W-1:0] col_req);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= S_TDATA_W'({col_req, row_req, ch});
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	task automatic send_write(input logic [BYTE_W-1:0] ch);
		send_req(MODE_WRITE, ch, ROW_W'($urandom), COL_W'($urandom));
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [PX_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		if (idx == REG_WIDTH)
			cols_now = (val < GLYPH_WIDTH_DEF) ? 1 : val / GLYPH_WIDTH_DEF;
		else if (idx == REG_HEIGHT)
			rows_now = (val < GLYPH_HEIGHT_DEF) ? 1 : val / GLYPH_HEIGHT_DEF;
	endtask

	// hold the stream idle until every result is back
	task automatic drain();
		int unsigned guard;
		guard = 0;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0 && guard < 50000) begin
			@(posedge clk);
			guard++;
		end
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [7:0] first_cont_min(input logic [7:0] lead);
		return (lead == 8'hE0) ? 8'hA0 : (lead == 8'hF0) ? 8'h90 : 8'h80;
	endfunction

	function automatic logic [7:0] first_cont_max(input logic [7:0] lead);
		return (lead == 8'hED) ? 8'h9F : (lead == 8'hF4) ? 8'h8F : 8'hBF;
	endfunction

	function automatic int unsigned pick_position(input int unsigned count,
			input int unsigned span);
		case ($urandom_range(0, 3))
		0: return 0;
		1: return count - 1;
		2: return count;
		default: return $urandom_range(0, span);
		endcase
	endfunction

	task automatic send_random_burst();
		int unsigned pick, ncont;
		logic [7:0] lead, bad;
		pick = $urandom_range(0, 99);
		if (pick < 28) begin
			send_write(8'($urandom_range(0, 8'h7F)));
		end else if (pick < 58) begin
			case ($urandom_range(0, 2))
			0: lead = 8'($urandom_range(8'hC2, 8'hDF));
			1: lead = 8'($urandom_range(8'hE0, 8'hEF));
			default: lead = 8'($urandom_range(8'hF0, 8'hF4));
			endcase
			ncont = (lead >= 8'hF0) ? 3 : (lead >= 8'hE0) ? 2 : 1;
			send_write(lead);
			send_write(8'($urandom_range(first_cont_min(lead), first_cont_max(lead))));
			repeat (ncont - 1) send_write(8'($urandom_range(8'h80, 8'hBF)));
		end else if (pick < 68) begin
			lead = 8'($urandom_range(8'hC2, 8'hF4));
			send_write(lead);
			if (lead >= 8'hE0 && $urandom_range(0, 1) == 1) begin
				send_write(8'($urandom_range(first_cont_min(lead), first_cont_max(lead))));
				// C0..17F wraps to C0..FF and 00..7F: never a continuation
				bad = 8'($urandom_range(8'hC0, 9'h17F));
			end else if ($urandom_range(0, 1) == 1) begin
				bad = 8'($urandom_range(8'hC0, 9'h17F));
			end else begin
				// just outside the allowed first continuation range
				bad = (first_cont_min(lead) != 8'h80) ? first_cont_min(lead) - 8'd1 :
					first_cont_max(lead) + 8'd1;
			end
			send_write(bad);
		end else if (pick < 78) begin
			case ($urandom_range(0, 2))
			0: send_write(CHAR_LF);
			1: send_write(CHAR_CR);
			default: send_write(CHAR_TAB);
			endcase
		end else if (pick < 86) begin
			send_write(8'($urandom_range(0, 255)));
		end else if (pick < 94) begin
			send_req(MODE_SET, 8'($urandom), 8'(pick_position(rows_now, 255)),
				9'(pick_position(cols_now, 511)));
		end else if (pick < 96) begin
			send_req(MODE_CLEAR, 8'($urandom), 8'($urandom), 9'($urandom));
		end else begin
			send_req(MODE_NOP, 8'($urandom), 8'($urandom), 9'($urandom));
		end
	endtask

	initial begin
		int unsigned phase_w[4];
		int unsigned phase_h[4];
		int unsigned phase_tx[4];
		int unsigned phase_rx[4];
		int unsigned phase_len[4];
		int unsigned target, saved_pct;
		bit stressed;

		phase_w   = '{40, 4095, 0, 8};
		phase_h   = '{48, 4095, 31, 4095};
		phase_tx  = '{32, 81, 0, 0};
		phase_rx  = '{81, 32, 0, 0};
		phase_len = '{240, 240, 160, 160};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed opening on the reset screen size
		send_write(8'h41);
		send_write(8'h00);
		send_write(8'h7F);
		send_write(CHAR_TAB);
		send_write(CHAR_CR);
		send_write(CHAR_LF);
		send_write(8'hC2);
		send_write(8'h80);
		send_write(8'hE0);
		send_write(8'hA0);
		send_write(8'h80);
		send_write(8'hF4);
		send_write(8'h8F);
		send_write(8'hBF);
		send_write(8'hBF);
		send_write(8'hED);
		send_write(8'hA0);
		send_write(8'hC2);
		send_write(CHAR_LF);
		send_req(MODE_SET, 8'h00, 8'd255, 9'd511);
		send_req(MODE_NOP, 8'hFF, 8'hFF, 9'h1FF);
		// a clear in the middle of a sequence leaves the decoder alone
		send_write(8'hC2);
		send_req(MODE_CLEAR, 8'h00, 8'h00, 9'h000);
		send_write(8'h80);
		send_req(MODE_SET, 8'h00, 8'd20, 9'd70);
		send_write(8'h41);
		drain();

		stressed = 1'b0;
		for (int ph = 0; ph < 4; ph++) begin
			tx_idle_pct = phase_tx[ph];
			rx_idle_pct = phase_rx[ph];
			write_reg(REG_WIDTH, PX_W'(phase_w[ph]));
			write_reg(REG_HEIGHT, PX_W'(phase_h[ph]));
			if (ph == 1) write_reg(REG_UNUSED_LO, 12'h5A5);
			if (ph == 3) write_reg(REG_UNUSED_HI, 12'hFFF);
			// cursor now sits below the shrunken screen: scroll mid-sequence
			if (ph == 0) begin
				send_write(8'hC3);
				send_write(8'hA9);
			end
			target = items_sent + phase_len[ph];
			while (items_sent < target) begin
				if (!stressed && ph == 0 && items_sent + 120 >= target) begin
					stressed = 1'b1;
					rx_hold_req = 1'b1;
					saved_pct = tx_idle_pct;
					tx_idle_pct = 0;
					repeat (30) send_write(8'($urandom_range(8'h20, 8'h7E)));
					tx_idle_pct = saved_pct;
				end
				if (ph == 1 && items_sent + 120 == target)
					drain();
				send_random_burst();
			end
			drain();
		end

		if (err_count == 0 && outstanding == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#3000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
